FILE: rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] item_data;
    logic signed [15:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_data;
    logic signed [15:0] out_priority;
    logic [4:0]         occupancy;
  } spq_out_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [15:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t entry;
  } spq_ctl_t;

endpackage

FILE: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, fill count and result register.
// The queue takes one command per cycle (busy stays low) and answers every
// transaction with exactly one result, shown for one cycle with out_valid
// high, in the cycle after start. All slots compare against the new priority in
// parallel and shift together, so an enqueue or a dequeue updates every slot
// at once. The receiver cannot stall; it must take each result when
// out_valid is high. An enqueue to a full queue is dropped with status full,
// a dequeue on an empty queue returns status empty.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  in_item,
  output logic     out_valid,
  output spq_out_t out_result
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          out_valid_r;
  spq_out_t      result_r;
  spq_out_t      result_nxt;

  logic          accept;
  logic          full;
  logic          empty;
  spq_ctl_t      ctl;
  logic [CW+4:0] cnt_ext;

  logic       ins   [CAPACITY];
  logic       valid [CAPACITY];
  spq_entry_t entry [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (cnt_r == CW'(CAPACITY));
  assign empty  = (cnt_r == '0);

  // Decode the command into shift controls for the chain
  always_comb begin
    ctl.enq        = accept && (in_item.cmd == CMD_ENQ) && !full;
    ctl.deq        = accept && (in_item.cmd == CMD_DEQ) && !empty;
    ctl.entry.data = in_item.item_data;
    ctl.entry.prio = in_item.item_priority;
  end

  // Build the chain of slots
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t prev_entry;
    spq_entry_t next_entry;
    logic       prev_ins;

    assign valid[i] = (CW'(i) < cnt_r);

    if (i == 0) begin : g_head
      assign prev_ins   = 1'b0;
      assign prev_entry = ctl.entry;
    end else begin : g_body
      assign prev_ins   = ins[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = entry[i];
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .ctl_i        (ctl),
      .valid_i      (valid[i]),
      .prev_ins_i   (prev_ins),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .ins_o        (ins[i]),
      .entry_o      (entry[i])
    );
  end

  // Advance the fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.enq) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (ctl.deq) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  assign cnt_ext = {5'd0, cnt_nxt};

  // Form the result of this transaction
  always_comb begin
    result_nxt.status       = ST_OK;
    result_nxt.out_data     = '0;
    result_nxt.out_priority = '0;
    result_nxt.occupancy    = cnt_ext[4:0];
    if (in_item.cmd == CMD_ENQ) begin
      if (full) begin
        result_nxt.status = ST_FULL;
      end
    end else if (empty) begin
      result_nxt.status = ST_EMPTY;
    end else begin
      result_nxt.out_data     = entry[0].data;
      result_nxt.out_priority = entry[0].prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= accept;
    end
  end

  // Hold the result for its one-cycle strobe
  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

FILE: rtl/spq_cell.sv
// One slot of the queue: holds an entry and shifts with its neighbors.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  spq_ctl_t   ctl_i,
  input  logic       valid_i,
  input  logic       prev_ins_i,
  input  spq_entry_t prev_entry_i,
  input  spq_entry_t next_entry_i,
  output logic       ins_o,
  output spq_entry_t entry_o
);

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  // Flag slots that must move back: empty or holding a larger priority
  assign ins_o = !valid_i || (entry_r.prio > ctl_i.entry.prio);

  // Take the new entry at the insert point, shift behind it, shift forward on dequeue
  always_comb begin
    entry_nxt = entry_r;
    if (ctl_i.enq && ins_o) begin
      entry_nxt = prev_ins_i ? prev_entry_i : ctl_i.entry;
    end else if (ctl_i.deq) begin
      entry_nxt = next_entry_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule

FILE: verif/sorted_priority_queue_tb.sv
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 20;

  // One row of the directed table; want is used only when typed is set
  typedef struct {
    spq_in_t  item;
    bit       typed;
    spq_out_t want;
  } stim_row_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spq_in_t  in_item = '0;
  logic     out_valid;
  spq_out_t out_result;

  // Shadow copy of the queue contents, slot 0 is the head
  spq_entry_t held[SPQ_CAPACITY];
  int         held_count;

  spq_out_t   pending_results[$];
  stim_row_t  directed_rows[$];

  int error_count  = 0;
  int cycle_count  = 0;
  int sent_count   = 0;
  int enq_ok_count = 0;
  int drop_count   = 0;
  int deq_ok_count = 0;
  int empty_count  = 0;
  int peak_fill    = 0;

  sorted_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Print one mismatch line (up to a cap) and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_LIMIT)
      $display("Mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Apply one command to the shadow queue and return the result it yields
  function automatic spq_out_t predict_queue_step(input spq_in_t item);
    int       pos;
    spq_out_t res;
    res = '0;
    if (item.cmd == CMD_ENQ) begin
      if (held_count >= SPQ_CAPACITY) begin
        res.status = ST_FULL;
        drop_count++;
      end else begin
        // Insert behind every entry of lower or equal priority
        pos = 0;
        while (pos < held_count &&
               $signed(held[pos].prio) <= $signed(item.item_priority))
          pos++;
        for (int k = held_count; k > pos; k--)
          held[k] = held[k-1];
        held[pos].data = item.item_data;
        held[pos].prio = item.item_priority;
        held_count++;
        res.status = ST_OK;
        enq_ok_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
        empty_count++;
      end else begin
        // Pop the head and advance the rest
        res.status       = ST_OK;
        res.out_data     = held[0].data;
        res.out_priority = held[0].prio;
        for (int k = 1; k < held_count; k++)
          held[k-1] = held[k];
        held_count--;
        deq_ok_count++;
      end
    end
    if (held_count > peak_fill)
      peak_fill = held_count;
    res.occupancy = 5'(held_count);
    return res;
  endfunction

  // Present one transaction, hold it until accepted, then record the expected result
  task automatic send_item(input spq_in_t item, input bit typed, input spq_out_t want);
    spq_out_t predicted;
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_queue_step(item);
    pending_results.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  function automatic void add_row(input logic cmd, input logic [31:0] data,
                                  input logic [15:0] prio, input bit typed,
                                  input spq_out_t want);
    stim_row_t row;
    row.item.cmd           = cmd;
    row.item.item_data     = data;
    row.item.item_priority = prio;
    row.typed              = typed;
    row.want               = want;
    directed_rows.push_back(row);
  endfunction

  // Check every result against the oldest expectation
  always @(posedge clk) begin
    spq_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_result.out_data, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_result.status !== want.status)
          report_mismatch("status", 32'(out_result.status), 32'(want.status));
        if (out_result.out_data !== want.out_data)
          report_mismatch("out_data", out_result.out_data, want.out_data);
        if (out_result.out_priority !== want.out_priority)
          report_mismatch("out_priority", 32'(out_result.out_priority),
                          32'(want.out_priority));
        if (out_result.occupancy !== want.occupancy)
          report_mismatch("occupancy", 32'(out_result.occupancy), 32'(want.occupancy));
      end
    end
  end

  // Stimulus
  initial begin
    spq_in_t item;
    int      enq_pct;
    int      segment_left;
    int      burst_left;
    int      gap;
    int      pick;

    held_count   = 0;
    enq_pct      = 50;
    segment_left = 0;
    burst_left   = 0;

    // Directed table: empty dequeue, extremes, ties, fill to capacity, full drop, dequeues
    add_row(CMD_DEQ, 32'h0000_0000, 16'h0000, 1'b1, spq_out_t'{ST_EMPTY, 0, 0, 5'd0});
    add_row(CMD_ENQ, 32'h7FFF_FFFF, 16'h7FFF, 1'b1, spq_out_t'{ST_OK, 0, 0, 5'd1});
    add_row(CMD_ENQ, 32'h8000_0000, 16'h8000, 1'b1, spq_out_t'{ST_OK, 0, 0, 5'd2});
    add_row(CMD_ENQ, 32'hFFFF_FFFF, 16'h0000, 1'b0, '0);
    add_row(CMD_ENQ, 32'h0000_0000, 16'h0000, 1'b0, '0);
    add_row(CMD_ENQ, 32'h0000_0005, 16'h0005, 1'b0, '0);
    add_row(CMD_ENQ, 32'hDEAD_BEEF, 16'hFFFD, 1'b0, '0);
    add_row(CMD_ENQ, 32'h0000_0006, 16'h0005, 1'b0, '0);
    add_row(CMD_ENQ, 32'h1234_5678, 16'h0064, 1'b0, '0);
    add_row(CMD_ENQ, 32'hA5A5_A5A5, 16'hFFFD, 1'b0, '0);
    add_row(CMD_ENQ, 32'h5A5A_5A5A, 16'h7FFF, 1'b0, '0);
    add_row(CMD_ENQ, 32'h8000_0001, 16'h8000, 1'b0, '0);
    add_row(CMD_ENQ, 32'h0000_0001, 16'h0001, 1'b0, '0);
    add_row(CMD_ENQ, 32'h0000_0007, 16'h0005, 1'b0, '0);
    add_row(CMD_ENQ, 32'hCAFE_F00D, 16'h0000, 1'b0, '0);
    add_row(CMD_ENQ, 32'h0F0F_0F0F, 16'hFFFF, 1'b0, '0);
    add_row(CMD_ENQ, 32'hF0F0_F0F0, 16'h0002, 1'b0, '0);
    add_row(CMD_ENQ, 32'h1111_1111, 16'h0001, 1'b1, spq_out_t'{ST_FULL, 0, 0, 5'd16});
    add_row(CMD_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
            spq_out_t'{ST_OK, 32'h8000_0000, 16'h8000, 5'd15});
    add_row(CMD_DEQ, 32'h0000_0000, 16'h0000, 1'b0, '0);
    add_row(CMD_DEQ, 32'h0000_0000, 16'h0000, 1'b0, '0);

    // Reset
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table back to back
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Random traffic in segments that lean toward filling, draining or balance
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (segment_left == 0) begin
        pick         = $urandom_range(0, 2);
        enq_pct      = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
        segment_left = $urandom_range(20, 80);
      end
      segment_left--;

      // Idle between bursts; some bursts run long with no gaps at all
      if (burst_left == 0) begin
        gap        = $urandom_range(0, 6);
        burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 30);
        if (gap > 0) begin
          start   <= 1'b0;
          in_item <= spq_in_t'({$urandom, $urandom});
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;

      item.cmd       = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      item.item_data = $urandom;
      pick           = $urandom_range(0, 9);
      if (pick < 5)
        item.item_priority = 16'($signed($urandom_range(0, 7)) - 4);
      else if (pick < 8)
        item.item_priority = 16'($urandom);
      else if (pick == 8)
        item.item_priority = 16'h8000;
      else
        item.item_priority = 16'h7FFF;
      send_item(item, 1'b0, '0);
    end
    start <= 1'b0;

    // Drain outstanding results, then keep watching for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transactions: %0d enqueues stored, %0d dropped when full",
             sent_count, enq_ok_count, drop_count);
    $display("%0d dequeues served, %0d on empty queue, peak fill %0d, %0d mismatches",
             deq_ok_count, empty_count, peak_fill, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
